[rtl/sjfb_pkg.sv]
// ----------------------------------------------------------------------------
// sjfb_pkg: shared types for the SJF batch scheduler
// Beat layouts, stored job entry, controller states and size defaults.
// ----------------------------------------------------------------------------
package sjfb_pkg;

  // Default batch capacity
  localparam int unsigned MaxJobsDef = 16;

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned ClockW = 21;
  localparam int unsigned TotalW = 25;

  // Input beat: one job
  typedef struct packed {
    logic [IdW-1:0]   job_id;
    logic [TimeW-1:0] arrive_at;
    logic [TimeW-1:0] burst_len;
    logic             batch_last;
  } job_in_t;

  // Output beat: one scheduled job
  typedef struct packed {
    logic [IdW-1:0]    job_id_res;
    logic [TimeW-1:0]  arrival_echo;
    logic [TimeW-1:0]  burst_echo;
    logic [ClockW-1:0] completion_time;
    logic [ClockW-1:0] turnaround_time;
    logic [ClockW-1:0] wait_len;
    logic [TotalW-1:0] total_turnaround;
    logic [TotalW-1:0] total_waiting;
    logic              result_last;
  } job_res_t;

  // Entry held in the job memory
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
  } job_entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,   // accept job beats
    ST_SCAN,   // sweep memory for the next job
    ST_CALC,   // start and completion time
    ST_DIFF,   // turnaround and waiting time
    ST_EMIT    // totals, load output register
  } sched_state_e;

endpackage

[rtl/sjfb_job_mem.sv]
// ----------------------------------------------------------------------------
// sjfb_job_mem: job entry storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module sjfb_job_mem #(
  parameter int unsigned DEPTH = sjfb_pkg::MaxJobsDef,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  sjfb_pkg::job_entry_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output sjfb_pkg::job_entry_t rd_data_o
);
  import sjfb_pkg::*;

  job_entry_t mem [DEPTH];
  job_entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/sjf_batch_scheduler_core.sv]
// ----------------------------------------------------------------------------
// sjf_batch_scheduler_core: non-preemptive shortest-job-first batch scheduler
// Loads a batch of jobs into memory, then emits them in SJF run order with
// completion, turnaround, waiting times and running totals.
// ----------------------------------------------------------------------------
//
//   channel | signals                            | beat
//   --------+------------------------------------+-------------------------
//   in      | in_valid_i  in_ready_o  in_data_i  | one job (job_in_t)
//   out     | out_valid_o out_ready_i out_data_o | one scheduled job (job_res_t)
//
// Loading takes one cycle per job beat. Each result of a batch of n jobs comes
// from a sweep of n memory reads, a wait for the last read data and a step that
// closes the sweep, then three arithmetic steps. No job beat is taken during
// scheduling. Reset empties the batch; memory contents need no clearing. A
// stalled result holds the controller in its emit step until the output
// register frees.
//
module sjf_batch_scheduler_core #(
  parameter int unsigned MAX_JOBS = sjfb_pkg::MaxJobsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sjfb_pkg::job_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sjfb_pkg::job_res_t out_data_o
);
  import sjfb_pkg::*;

  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_JOBS);

  // Control state
  sched_state_e      state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]   rd_tag_q, rd_tag_d;
  logic [CntW-1:0]   emit_cnt_q, emit_cnt_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic [ClockW-1:0] clock_q, clock_d;
  logic              ba_found_q, ba_found_d;
  logic              ep_found_q, ep_found_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers
  job_entry_t        ba_q, ba_d, ep_q, ep_d, sel_q, sel_d;
  logic [IdxW-1:0]   ba_idx_q, ba_idx_d, ep_idx_q, ep_idx_d, sel_idx_q, sel_idx_d;
  logic [ClockW-1:0] start_q, start_d, comp_q, comp_d, ta_q, ta_d, wt_q, wt_d;
  logic [TotalW-1:0] tot_ta_q, tot_ta_d, tot_wt_q, tot_wt_d;
  job_res_t          out_q, out_d;

  // Memory ports
  logic              wr_en, rd_en;
  job_entry_t        wr_data, rd_data;

  assign wr_data.id      = in_data_i.job_id;
  assign wr_data.arrival = in_data_i.arrive_at;
  assign wr_data.burst   = in_data_i.burst_len;

  sjfb_job_mem #(
    .DEPTH (MAX_JOBS)
  ) u_job_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Scan candidate tests on the entry coming out of memory
  logic entry_live, entry_arrived, ba_better, ep_better;
  assign entry_live    = rd_vld_q && !done_q[rd_tag_q];
  assign entry_arrived = ClockW'(rd_data.arrival) <= clock_q;
  assign ba_better     = !ba_found_q || (rd_data.burst < ba_q.burst) ||
                         ((rd_data.burst == ba_q.burst) && (rd_data.arrival < ba_q.arrival));
  assign ep_better     = !ep_found_q || (rd_data.arrival < ep_q.arrival) ||
                         ((rd_data.arrival == ep_q.arrival) && (rd_data.burst < ep_q.burst));

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    rd_tag_d   = rd_tag_q;
    emit_cnt_d = emit_cnt_q;
    done_d     = done_q;
    clock_d    = clock_q;
    ba_found_d = ba_found_q;
    ep_found_d = ep_found_q;
    ba_d       = ba_q;
    ba_idx_d   = ba_idx_q;
    ep_d       = ep_q;
    ep_idx_d   = ep_idx_q;
    sel_d      = sel_q;
    sel_idx_d  = sel_idx_q;
    start_d    = start_q;
    comp_d     = comp_q;
    ta_d       = ta_q;
    wt_d       = wt_q;
    tot_ta_d   = tot_ta_q;
    tot_wt_d   = tot_wt_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en      = 1'b0;
    rd_en      = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          // drop job data once the batch is full
          if (count_q < MaxCnt) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end
          if (in_data_i.batch_last) begin
            state_d    = ST_SCAN;
            rd_idx_d   = '0;
            ba_found_d = 1'b0;
            ep_found_d = 1'b0;
            emit_cnt_d = '0;
            clock_d    = '0;
            done_d     = '0;
            tot_ta_d   = '0;
            tot_wt_d   = '0;
          end
        end
      end

      ST_SCAN: begin
        // issue reads in load order
        if (rd_idx_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_tag_d = rd_idx_q[IdxW-1:0];
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        // fold returning entries into both candidates; strict compares keep load order
        if (entry_live) begin
          if (entry_arrived && ba_better) begin
            ba_found_d = 1'b1;
            ba_d       = rd_data;
            ba_idx_d   = rd_tag_q;
          end
          if (ep_better) begin
            ep_found_d = 1'b1;
            ep_d       = rd_data;
            ep_idx_d   = rd_tag_q;
          end
        end
        if (!(rd_idx_q < count_q) && !rd_vld_q) begin
          state_d = ST_CALC;
        end
      end

      ST_CALC: begin
        // nothing arrived: clock jumps to the earliest pending arrival
        if (ba_found_q) begin
          sel_d     = ba_q;
          sel_idx_d = ba_idx_q;
          start_d   = clock_q;
          comp_d    = clock_q + ClockW'(ba_q.burst);
        end else begin
          sel_d     = ep_q;
          sel_idx_d = ep_idx_q;
          start_d   = ClockW'(ep_q.arrival);
          comp_d    = ClockW'(ep_q.arrival) + ClockW'(ep_q.burst);
        end
        state_d = ST_DIFF;
      end

      ST_DIFF: begin
        ta_d              = comp_q - ClockW'(sel_q.arrival);
        wt_d              = start_q - ClockW'(sel_q.arrival);
        done_d[sel_idx_q] = 1'b1;
        clock_d           = comp_q;
        state_d           = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          tot_ta_d = tot_ta_q + TotalW'(ta_q);
          tot_wt_d = tot_wt_q + TotalW'(wt_q);
          out_d.job_id_res       = sel_q.id;
          out_d.arrival_echo     = sel_q.arrival;
          out_d.burst_echo       = sel_q.burst;
          out_d.completion_time  = comp_q;
          out_d.turnaround_time  = ta_q;
          out_d.wait_len         = wt_q;
          out_d.total_turnaround = tot_ta_q + TotalW'(ta_q);
          out_d.total_waiting    = tot_wt_q + TotalW'(wt_q);
          out_d.result_last      = ((emit_cnt_q + CntW'(1)) == count_q);
          out_valid_d            = 1'b1;
          emit_cnt_d             = emit_cnt_q + CntW'(1);
          if ((emit_cnt_q + CntW'(1)) == count_q) begin
            // batch finished, start a new one
            state_d = ST_LOAD;
            count_d = '0;
            done_d  = '0;
            clock_d = '0;
          end else begin
            state_d    = ST_SCAN;
            rd_idx_d   = '0;
            ba_found_d = 1'b0;
            ep_found_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_tag_q    <= '0;
      emit_cnt_q  <= '0;
      done_q      <= '0;
      clock_q     <= '0;
      ba_found_q  <= 1'b0;
      ep_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      rd_tag_q    <= rd_tag_d;
      emit_cnt_q  <= emit_cnt_d;
      done_q      <= done_d;
      clock_q     <= clock_d;
      ba_found_q  <= ba_found_d;
      ep_found_q  <= ep_found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ba_q      <= ba_d;
    ba_idx_q  <= ba_idx_d;
    ep_q      <= ep_d;
    ep_idx_q  <= ep_idx_d;
    sel_q     <= sel_d;
    sel_idx_q <= sel_idx_d;
    start_q   <= start_d;
    comp_q    <= comp_d;
    ta_q      <= ta_d;
    wt_q      <= wt_d;
    tot_ta_q  <= tot_ta_d;
    tot_wt_q  <= tot_wt_d;
    out_q     <= out_d;
  end

endmodule
